FILE: hdl/ract_pkg.sv
// Shared types, constants and the CORDIC angle table for the rotation capture trigger.
package ract_pkg;
    localparam int MAX_STREAMS = 16;
    localparam int ANGLE_BITS  = 16;
    localparam int TOTAL_BITS  = 40;
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W      = 5;
    localparam int VEC_W       = 36;
    localparam int MAG_W       = TOTAL_BITS;
    localparam int DIV_STEPS   = 25;
    localparam logic [23:0] TRIG_MAX  = 24'hFFFFFF;
    localparam logic [15:0] WAIT_MAX  = 16'hFFFF;
    localparam logic [19:0] CNT20_MAX = 20'hFFFFF;
    localparam logic CFG_INTERVAL = 1'b0;
    localparam logic CFG_STREAMS  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CORDIC, ST_ACCUM, ST_DIV, ST_TRIG, ST_FRAME, ST_OUT
    } t_state;

    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B; 5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53; 5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
            default: v = 32'h0;
        endcase
        return v;
    endfunction
endpackage

FILE: hdl/ract_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation per cycle, heading in angle units.
module ract_cordic import ract_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [VEC_W-1:0] i_x,
    input  logic signed [VEC_W-1:0] i_y,
    output logic                   o_done,
    output logic [ANGLE_BITS-1:0]  o_angle
);
    logic signed [VEC_W+1:0] r_x, r_y, n_x, n_y;
    logic [31:0]             r_z, n_z;
    logic [STEP_W-1:0]       r_i, n_i;
    logic                    r_busy, n_busy, r_zero, n_zero, r_done, n_done;
    logic signed [VEC_W+1:0] xs, ys;
    logic [31:0]             zr;

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        n_x = r_x; n_y = r_y; n_z = r_z; n_i = r_i;
        n_busy = r_busy; n_zero = r_zero; n_done = 1'b0;
        if (i_start) begin
            n_zero = (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                n_x = -VEC_W'(0) - {{2{i_x[VEC_W-1]}}, i_x};
                n_y = -{{2{i_y[VEC_W-1]}}, i_y};
                n_z = 32'h80000000;
            end else begin
                n_x = {{2{i_x[VEC_W-1]}}, i_x};
                n_y = {{2{i_y[VEC_W-1]}}, i_y};
                n_z = '0;
            end
            n_i = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_y > 0) begin
                n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + atan_turn(r_i);
            end else begin
                n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - atan_turn(r_i);
            end
            n_i = r_i + STEP_W'(1);
            if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_i <= n_i; r_zero <= n_zero;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign zr = r_z + (32'd1 << (31 - ANGLE_BITS));
    assign o_done  = r_done;
    assign o_angle = r_zero ? '0 : zr[31 -: ANGLE_BITS];
endmodule

FILE: hdl/ract_divider.sv
// Restoring divider: magnitude over interval, one quotient bit per cycle, clamped to 24 bits.
module ract_divider import ract_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_num,
    input  logic [15:0]      i_den,
    output logic             o_done,
    output logic [23:0]      o_quot
);
    // The top 15 bits seed the remainder; when they already reach the divisor the
    // quotient is at least 2^25 and the result saturates.
    logic [14:0]      r_top;
    logic [24:0]      r_low;
    logic [16:0]      r_rem, n_rem;
    logic [24:0]      r_q;
    logic [15:0]      r_den;
    logic [4:0]       r_cnt;
    logic             r_busy, r_done;
    logic [16:0]      shifted;
    logic [17:0]      diff;

    assign shifted = {r_rem[15:0], r_low[24]};
    assign diff    = {1'b0, shifted} - {2'b0, r_den};
    assign n_rem   = diff[17] ? shifted : diff[16:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_top <= i_num[MAG_W-1 -: 15];
            r_low <= i_num[24:0];
            r_den <= i_den;
            r_rem <= {2'b00, i_num[MAG_W-1 -: 15]};
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= {r_low[23:0], 1'b0};
            r_q   <= {r_q[23:0], ~diff[17]};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_q[24] || ({1'b0, r_top} >= r_den)) ? TRIG_MAX : r_q[23:0];
endmodule

FILE: hdl/rotation_angle_capture_trigger_top.sv
// Top level of the rotation angle capture trigger: sequencer, counters and stream table.
// An odometry transaction runs from its acceptance to the next acceptance, when the receiver
// is ready, through these steps in order: form and load the vector, the 28 CORDIC steps,
// present the angle, update the total, start the restoring divider, the 25 divider steps,
// present the boundary count, add the new captures, the output phase and the return to
// idle. The first odometry transaction skips the divide. A frame transaction runs the frame
// update, the output phase and the return to idle. One transaction is in flight at a time;
// s_axis_tready is low while it runs and while its result waits in the output register,
// so a receiver stall delays the next acceptance. The stream frame table resets by
// valid bits, so no clearing pass follows reset.
module rotation_angle_capture_trigger_top import ract_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [135:0] m_axis_tdata, // captured, stream_index, frame_number, lap_finished,
                                       // laps_total, new_triggers, pending_total,
                                       // turned_angle, heading, zero fill
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    t_state r_state, n_state;
    logic [15:0] r_interval;
    logic [4:0]  r_streams;
    logic [15:0] r_prev;
    logic        r_hvalid;
    logic signed [TOTAL_BITS-1:0] r_total;
    logic [23:0] r_issued;
    logic [15:0] r_wait;
    logic [3:0]  r_ptr;
    logic [19:0] r_frames [MAX_STREAMS];
    logic [MAX_STREAMS-1:0] r_fvalid;
    logic [19:0] r_laps;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;
    logic signed [VEC_W-1:0] r_cs, r_sn;
    logic [15:0] r_cur;
    logic        r_cap, r_lap;
    logic [3:0]  r_sidx;
    logic [19:0] r_fnum;
    logic [15:0] r_newt;
    logic        r_ovalid;
    logic        cordic_start, cordic_done, div_start, div_done;
    logic [15:0] cordic_angle;
    logic [23:0] div_quot;
    logic [MAG_W-1:0] mag;
    logic [15:0] ivl;
    // start strobes fire once per phase
    logic        r_busy_c, r_busy_d, r_vec_rdy;

    assign ivl = (r_interval == '0) ? 16'd1 : r_interval;
    assign mag = r_total[TOTAL_BITS-1] ? MAG_W'(-r_total) : MAG_W'(r_total);

    ract_cordic u_cordic (
        .i_clk, .i_rst_n, .i_start(cordic_start), .i_x(r_cs), .i_y(r_sn),
        .o_done(cordic_done), .o_angle(cordic_angle));
    ract_divider u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(mag), .i_den(ivl),
        .o_done(div_done), .o_quot(div_quot));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (s_axis_tvalid) n_state = s_axis_tuser ? ST_FRAME : ST_CORDIC;
            ST_CORDIC: if (cordic_done) n_state = ST_ACCUM;
            ST_ACCUM:  begin
                n_state = r_hvalid ? ST_DIV : ST_OUT;
            end
            ST_DIV:    if (div_done) n_state = ST_TRIG;
            ST_TRIG:   n_state = ST_OUT;
            ST_FRAME:  n_state = ST_OUT;
            ST_OUT:    if (m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
        cordic_start = r_vec_rdy;
        div_start = (r_state == ST_DIV) && !r_busy_d;
    end

    // load the vector on the first CORDIC cycle, start the unit on the next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_c <= 1'b0;
            r_busy_d <= 1'b0;
            r_vec_rdy <= 1'b0;
        end else begin
            r_busy_c <= (r_state == ST_CORDIC) && !cordic_done;
            r_busy_d <= (r_state == ST_DIV) && !div_done;
            r_vec_rdy <= (r_state == ST_CORDIC) && !r_busy_c;
        end
    end

    // heading change, wrapped and folded
    logic [15:0] raw;
    logic signed [17:0] d;
    logic signed [TOTAL_BITS:0] sum;
    assign raw = r_cur - r_prev;
    always_comb begin
        d = raw[15] ? 18'(signed'({2'b11, raw})) : 18'({2'b00, raw});
        if (d < -18'sd16384) d = d + 18'sd65536;
        sum = {r_total[TOTAL_BITS-1], r_total} + (TOTAL_BITS+1)'(d);
    end

    logic [3:0] nstr, idx;
    logic [4:0] nclamp;
    assign nclamp = (r_streams == '0) ? 5'd1 : (r_streams > 5'd16 ? 5'd16 : r_streams);
    assign idx = ({1'b0, r_ptr} >= nclamp) ? 4'd0 : r_ptr;
    assign nstr = 4'(nclamp - 5'd1);
    logic [19:0] fcur;
    assign fcur = r_fvalid[idx] ? r_frames[idx] : '0;
    logic [24:0] wsum;
    logic [23:0] ntrig;
    assign ntrig = div_quot - r_issued;
    assign wsum = {9'd0, r_wait} + {1'b0, ntrig};

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_qw <= s_axis_tdata[15:0];  r_qx <= s_axis_tdata[31:16];
            r_qy <= s_axis_tdata[47:32]; r_qz <= s_axis_tdata[63:48];
        end
        if (r_state == ST_CORDIC && !r_busy_c) begin
            r_sn <= VEC_W'(2 * (36'(r_qw) * 36'(r_qz) + 36'(r_qx) * 36'(r_qy)));
            r_cs <= VEC_W'(36'sd268435456 - 2 * (36'(r_qy) * 36'(r_qy) + 36'(r_qz) * 36'(r_qz)));
        end
        if (cordic_done) r_cur <= cordic_angle;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_interval <= 16'd16384; r_streams <= 5'd4;
            r_prev <= '0; r_hvalid <= 1'b0; r_total <= '0; r_issued <= '0;
            r_wait <= '0; r_ptr <= '0; r_fvalid <= '0; r_laps <= '0; r_ovalid <= 1'b0;
            r_cap <= 1'b0; r_lap <= 1'b0; r_sidx <= '0; r_fnum <= '0; r_newt <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_INTERVAL) r_interval <= i_cfg_data;
                else r_streams <= i_cfg_data[4:0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_cap <= 1'b0; r_lap <= 1'b0; r_sidx <= '0; r_fnum <= '0; r_newt <= '0;
            end
            if (r_state == ST_ACCUM) begin
                r_prev <= r_cur;
                r_hvalid <= 1'b1;
                if (r_hvalid) begin
                    if (sum[TOTAL_BITS] != sum[TOTAL_BITS-1])
                        r_total <= sum[TOTAL_BITS] ? {1'b1, {(TOTAL_BITS-1){1'b0}}}
                                                   : {1'b0, {(TOTAL_BITS-1){1'b1}}};
                    else r_total <= sum[TOTAL_BITS-1:0];
                end
            end
            if (r_state == ST_TRIG && div_quot > r_issued) begin
                r_wait <= (wsum > 25'(WAIT_MAX)) ? WAIT_MAX : wsum[15:0];
                r_newt <= (ntrig > 24'hFFFF) ? 16'hFFFF : ntrig[15:0];
                r_issued <= div_quot;
            end
            if (r_state == ST_FRAME && r_wait != '0) begin
                r_cap <= 1'b1; r_sidx <= idx; r_fnum <= fcur;
                r_frames[idx] <= (fcur < CNT20_MAX) ? fcur + 20'd1 : fcur;
                r_fvalid[idx] <= 1'b1;
                if (idx == nstr) begin
                    r_lap <= 1'b1; r_ptr <= '0;
                    if (r_laps < CNT20_MAX) r_laps <= r_laps + 20'd1;
                end else r_ptr <= idx + 4'd1;
                r_wait <= r_wait - 16'd1;
            end
            if (n_state == ST_OUT && r_state != ST_OUT) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tdata = {2'b00, r_prev, r_total, r_wait, r_newt, r_laps, r_lap,
                           r_fnum, r_sidx, r_cap};

    // A result is shown only after the work of its transaction is over
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_state == ST_OUT) else $error("result outside output phase");
    // No input is taken while a result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
    // A capture always consumes one waiting item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FRAME && r_wait != '0) |=> r_wait == $past(r_wait) - 16'd1)
        else $error("pending count not decremented");
endmodule
